/* sv/ascii_radio_frame_encoder_unit_macros.svh */
// Assertion macros shared by the frame encoder RTL.
`ifndef ASCII_RADIO_FRAME_ENCODER_UNIT_MACROS_SVH
`define ASCII_RADIO_FRAME_ENCODER_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ARFE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ARFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/arfe_pkg.sv */
// Types, character codes and frame layout tables for the frame encoder.
`default_nettype none

package arfe_pkg;

    localparam int ADDR_W = 27;
    localparam int POS_W  = 6;

    localparam logic [ADDR_W-1:0] ADDR_MAX = 27'd99999999;

    // Frame kinds
    localparam logic KIND_NODE    = 1'b0;
    localparam logic KIND_GATEWAY = 1'b1;

    // Slot classes
    localparam logic [1:0] SLOT_CHAR   = 2'd0;
    localparam logic [1:0] SLOT_DIGIT  = 2'd1;
    localparam logic [1:0] SLOT_HEX_HI = 2'd2;
    localparam logic [1:0] SLOT_HEX_LO = 2'd3;

    // Number fields
    localparam logic [2:0] FLD_DEST = 3'd0;
    localparam logic [2:0] FLD_OWN  = 3'd1;
    localparam logic [2:0] FLD_DEV  = 3'd2;
    localparam logic [2:0] FLD_SEQ  = 3'd3;
    localparam logic [2:0] FLD_CMD  = 3'd4;
    localparam logic [2:0] FLD_VAL  = 3'd5;

    // ASCII characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_HEX_AF = 8'h37;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic              frame_kind;
        logic [ADDR_W-1:0] dest_address;
        logic [ADDR_W-1:0] source_device;
        logic [7:0]        seq_or_level;
        logic [7:0]        command_code;
        logic [6:0]        payload_value;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } t_out_beat;

    // What the byte at one frame position is made of
    typedef struct packed {
        logic [1:0] code;
        logic [7:0] ch;
        logic [2:0] fld;
        logic [2:0] expo;
        logic       last;
    } t_slot;

    // Result of one decimal digit step
    typedef struct packed {
        logic [3:0]        digit;
        logic [ADDR_W-1:0] rest;
    } t_digit;

    // Decode a frame position into its slot.
    function automatic t_slot slot_of(input logic kind, input logic [POS_W-1:0] pos);
        t_slot s;
        s.code = SLOT_CHAR;
        s.ch   = CH_NUL;
        s.fld  = FLD_DEST;
        s.expo = 3'd0;
        s.last = 1'b0;
        if (kind == KIND_NODE) begin
            case (pos) inside
                6'd0: s.ch = CH_LBRACE;
                [6'd1:6'd8]: begin
                    s.code = SLOT_DIGIT; s.fld = FLD_DEST; s.expo = 3'(6'd8 - pos);
                end
                6'd9, 6'd18, 6'd22, 6'd25: s.ch = CH_COMMA;
                [6'd10:6'd17]: begin
                    s.code = SLOT_DIGIT; s.fld = FLD_OWN; s.expo = 3'(6'd17 - pos);
                end
                [6'd19:6'd21]: begin
                    s.code = SLOT_DIGIT; s.fld = FLD_SEQ; s.expo = 3'(6'd21 - pos);
                end
                [6'd23:6'd24]: begin
                    s.code = SLOT_DIGIT; s.fld = FLD_CMD; s.expo = 3'(6'd24 - pos);
                end
                6'd26: begin
                    s.code = SLOT_DIGIT; s.fld = FLD_VAL;
                end
                6'd27: s.ch = CH_RBRACE;
                6'd28: s.code = SLOT_HEX_HI;
                6'd29: s.code = SLOT_HEX_LO;
                6'd30: s.ch = CH_CR;
                6'd31: begin
                    s.ch = CH_LF; s.last = 1'b1;
                end
                default: s.last = 1'b1;
            endcase
        end else begin
            case (pos) inside
                6'd0, 6'd40: begin
                    s.ch = CH_G; s.last = (pos == 6'd40);
                end
                6'd1: s.ch = CH_LBRACE;
                [6'd2:6'd9]: begin
                    s.code = SLOT_DIGIT; s.fld = FLD_DEST; s.expo = 3'(6'd9 - pos);
                end
                6'd10, 6'd19, 6'd28, 6'd32, 6'd36: s.ch = CH_COMMA;
                [6'd11:6'd18]: begin
                    s.code = SLOT_DIGIT; s.fld = FLD_OWN; s.expo = 3'(6'd18 - pos);
                end
                [6'd20:6'd27]: begin
                    s.code = SLOT_DIGIT; s.fld = FLD_DEV; s.expo = 3'(6'd27 - pos);
                end
                [6'd29:6'd31]: begin
                    s.code = SLOT_DIGIT; s.fld = FLD_SEQ; s.expo = 3'(6'd31 - pos);
                end
                [6'd33:6'd35]: begin
                    s.code = SLOT_DIGIT; s.fld = FLD_CMD; s.expo = 3'(6'd35 - pos);
                end
                [6'd37:6'd38]: begin
                    s.code = SLOT_DIGIT; s.fld = FLD_VAL; s.expo = 3'(6'd38 - pos);
                end
                6'd39: s.ch = CH_RBRACE;
                default: s.last = 1'b1;
            endcase
        end
        return s;
    endfunction

    // Upper-case hex character of one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (CH_ZERO + {4'h0, nib}) : (CH_HEX_AF + {4'h0, nib});
    endfunction

    // Multiple d of the decimal weight 10**expo.
    function automatic logic [ADDR_W-1:0] dec_step(input logic [2:0] expo,
                                                    input logic [3:0] d);
        logic [ADDR_W-1:0] p;
        case (expo)
            3'd0:    p = 27'd1;
            3'd1:    p = 27'd10;
            3'd2:    p = 27'd100;
            3'd3:    p = 27'd1000;
            3'd4:    p = 27'd10000;
            3'd5:    p = 27'd100000;
            3'd6:    p = 27'd1000000;
            default: p = 27'd10000000;
        endcase
        return ADDR_W'(p * {23'd0, d});
    endfunction

endpackage

`default_nettype wire

/* sv/arfe_digit_unit.sv */
// Leading decimal digit of a value and the remainder below that digit.
`default_nettype none

module arfe_digit_unit
    import arfe_pkg::*;
(
    input  logic [ADDR_W-1:0] i_value,
    input  logic [2:0]        i_expo,
    output t_digit            o_res
);

    logic [3:0]        w_digit;
    logic [ADDR_W-1:0] w_thr;

    // Compare against every multiple of the weight, keep the largest that fits
    always_comb begin
        w_digit = 4'd0;
        w_thr   = '0;
        for (int d = 1; d <= 9; d++) begin
            if (i_value >= dec_step(i_expo, 4'(d))) begin
                w_digit = 4'(d);
                w_thr   = dec_step(i_expo, 4'(d));
            end
        end
    end

    assign o_res.digit = w_digit;
    assign o_res.rest  = i_value - w_thr;

endmodule

`default_nettype wire

/* sv/ascii_radio_frame_encoder_unit.sv */
// Top level of the ASCII radio frame encoder: message buffer, byte sequencer, output register.
`default_nettype none

// Each accepted message becomes one ASCII frame on the output channel, one byte per beat,
// with frame_end set on the last byte: a node frame (kind 0) is 32 bytes with a hex byte-sum
// checksum and CR LF, a gateway frame (kind 1) is 41 bytes. The byte sequencer emits one byte
// per cycle into the output register while the output takes beats, and holds while it stalls.
// An accepted message waits in the input buffer until it is loaded into the sequencer. A message
// waiting there starts right after the previous frame's last byte, so frames follow each other
// with no gap while the output keeps taking beats. Decimal digits are produced one per byte by
// a shared digit unit working on remainder registers. Numbers too wide for their digit field are
// clamped to the field's maximum. The own address register is written through the configuration
// channel, which is always ready; it resets to 40000000.

`include "ascii_radio_frame_encoder_unit_macros.svh"

module ascii_radio_frame_encoder_unit
    import arfe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_beat          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_beat         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ADDR_W-1:0] i_cfg_data
);

    logic [ADDR_W-1:0] r_own_addr;

    logic              r_buf_valid;
    t_in_beat          r_buf;

    logic              r_active;
    logic [POS_W-1:0]  r_pos;
    logic              r_kind;
    logic [7:0]        r_sum;
    logic [ADDR_W-1:0] r_dest;
    logic [ADDR_W-1:0] r_own;
    logic [ADDR_W-1:0] r_dev;
    logic [7:0]        r_seq;
    logic [7:0]        r_cmd;
    logic [6:0]        r_val;

    logic              r_out_valid;
    t_out_beat         r_out;

    logic              w_in_fire;
    logic              w_advance;
    logic              w_done;
    logic              w_load;
    t_slot             w_slot;
    logic [ADDR_W-1:0] w_dig_in;
    t_digit            w_dig;
    logic [7:0]        w_byte;

    logic [ADDR_W-1:0] n_dest;
    logic [ADDR_W-1:0] n_own;
    logic [ADDR_W-1:0] n_dev;
    logic [7:0]        n_seq;
    logic [7:0]        n_cmd;
    logic [6:0]        n_val;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= 27'd40000000;
        end else if (i_cfg_valid) begin
            r_own_addr <= i_cfg_data;
        end
    end

    // Handshake and sequencing control
    assign o_in_ready = !r_buf_valid;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_slot     = slot_of(r_kind, r_pos);
    assign w_advance  = r_active && (!r_out_valid || i_out_ready);
    assign w_done     = w_advance && w_slot.last;
    assign w_load     = r_buf_valid && (!r_active || w_done);

    // Hold one message while the current frame streams
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_buf_valid <= 1'b1;
        end else if (w_load) begin
            r_buf_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_buf <= i_in_data;
        end
    end

    // Clamp the numbers to their digit fields at load
    always_comb begin
        n_dest = (r_buf.dest_address > ADDR_MAX) ? ADDR_MAX : r_buf.dest_address;
        n_dev  = (r_buf.source_device > ADDR_MAX) ? ADDR_MAX : r_buf.source_device;
        n_own  = (r_own_addr > ADDR_MAX) ? ADDR_MAX : r_own_addr;
        if (r_buf.frame_kind == KIND_NODE) begin
            n_seq = r_buf.seq_or_level + 8'd1;
            n_cmd = (r_buf.command_code > 8'd99) ? 8'd99 : r_buf.command_code;
            n_val = (r_buf.payload_value > 7'd9) ? 7'd9 : r_buf.payload_value;
        end else begin
            n_seq = r_buf.seq_or_level;
            n_cmd = r_buf.command_code;
            n_val = (r_buf.payload_value > 7'd99) ? 7'd99 : r_buf.payload_value;
        end
    end

    // Select the field whose digit is due
    always_comb begin
        unique case (w_slot.fld)
            FLD_DEST: w_dig_in = r_dest;
            FLD_OWN:  w_dig_in = r_own;
            FLD_DEV:  w_dig_in = r_dev;
            FLD_SEQ:  w_dig_in = {19'd0, r_seq};
            FLD_CMD:  w_dig_in = {19'd0, r_cmd};
            FLD_VAL:  w_dig_in = {20'd0, r_val};
            default:  w_dig_in = '0;
        endcase
    end

    arfe_digit_unit u_digit (
        .i_value (w_dig_in),
        .i_expo  (w_slot.expo),
        .o_res   (w_dig)
    );

    // Form the byte of the current position
    always_comb begin
        unique case (w_slot.code)
            SLOT_CHAR:   w_byte = w_slot.ch;
            SLOT_DIGIT:  w_byte = CH_ZERO + {4'h0, w_dig.digit};
            SLOT_HEX_HI: w_byte = hex_char(r_sum[7:4]);
            SLOT_HEX_LO: w_byte = hex_char(r_sum[3:0]);
        endcase
    end

    // Advance the frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else if (w_load) begin
            r_active <= 1'b1;
            r_pos    <= '0;
        end else if (w_done) begin
            r_active <= 1'b0;
        end else if (w_advance) begin
            r_pos <= r_pos + 6'd1;
        end
    end

    // Load the fields, then drop each digit from its remainder as it goes out
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= r_buf.frame_kind;
            r_sum  <= 8'd0;
            r_dest <= n_dest;
            r_own  <= n_own;
            r_dev  <= n_dev;
            r_seq  <= n_seq;
            r_cmd  <= n_cmd;
            r_val  <= n_val;
        end else if (w_advance) begin
            // Sum text bytes only, so both checksum digits read the same sum
            if ((w_slot.code == SLOT_CHAR) || (w_slot.code == SLOT_DIGIT)) begin
                r_sum <= r_sum + w_byte;
            end
            if (w_slot.code == SLOT_DIGIT) begin
                case (w_slot.fld)
                    FLD_DEST: r_dest <= w_dig.rest;
                    FLD_OWN:  r_own  <= w_dig.rest;
                    FLD_DEV:  r_dev  <= w_dig.rest;
                    FLD_SEQ:  r_seq  <= w_dig.rest[7:0];
                    FLD_CMD:  r_cmd  <= w_dig.rest[7:0];
                    FLD_VAL:  r_val  <= w_dig.rest[6:0];
                    default:  r_dest <= r_dest;
                endcase
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out.out_byte  <= w_byte;
            r_out.frame_end <= w_slot.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `ARFE_ASSERT_SAME(a_digit_ascii, w_advance && (w_slot.code == SLOT_DIGIT),
        (w_byte >= CH_ZERO) && (w_byte <= CH_NINE), "digit slot produced a non-digit byte")
    `ARFE_ASSERT_SAME(a_node_len, r_active && (r_kind == KIND_NODE), r_pos <= 6'd31,
        "node frame ran past its last byte")
    `ARFE_ASSERT_SAME(a_frame_open, w_advance && (r_pos == 6'd0),
        (w_byte == CH_LBRACE) || (w_byte == CH_G), "frame opened with a wrong byte")
    `ARFE_ASSERT_NEXT(a_frame_restart, w_done, !r_active || (r_pos == 6'd0),
        "sequencer did not restart after the last byte")
    `ARFE_ASSERT_NEXT(a_buf_hold, r_buf_valid && !w_load, r_buf_valid,
        "buffered message lost before it was loaded")

endmodule

`default_nettype wire
